// ----- rtl/bhl_pkg.sv -----
// Shared constants, command codes and queue entry type of the byte histogram.
package bhl_pkg;

  localparam int LANES_DEFAULT      = 4;
  localparam int COUNT_BITS_DEFAULT = 32;
  localparam int BINS               = 256;
  localparam int BIN_BITS           = 8;
  localparam int BYTES_PER_ITEM     = 4;
  localparam int DATA_BITS          = 32;
  localparam int NBYTES_BITS        = 3;
  localparam int CMD_BITS           = 2;
  localparam int OUT_BITS           = 32;
  localparam int QUEUE_DEPTH        = 2;

  localparam logic [OUT_BITS-1:0] OUT_MAX = '1;

  localparam logic [CMD_BITS-1:0] CMD_COUNT = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    OP_COUNT = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef struct packed {
    op_t                    op;
    logic [DATA_BITS-1:0]   data_bytes;
    logic [NBYTES_BITS-1:0] byte_count;
    logic [BIN_BITS-1:0]    bin_index;
  } entry_t;

endpackage

// ----- rtl/bhl_if.sv -----
// Request and response channel interfaces of the byte histogram.
interface bhl_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [bhl_pkg::CMD_BITS-1:0]         command;
  logic [bhl_pkg::DATA_BITS-1:0]        data_bytes;
  logic [bhl_pkg::NBYTES_BITS-1:0]      byte_count;
  logic [bhl_pkg::BIN_BITS-1:0]         bin_index;

  modport source (output valid, command, data_bytes, byte_count, bin_index, input ready);
  modport sink   (input valid, command, data_bytes, byte_count, bin_index, output ready);
endinterface

interface bhl_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [bhl_pkg::OUT_BITS-1:0]   bin_count;
  logic [bhl_pkg::BIN_BITS-1:0]   bin_echo;

  modport source (output valid, bin_count, bin_echo, input ready);
  modport sink   (input valid, bin_count, bin_echo, output ready);
endinterface

// ----- rtl/byte_histogram_lanes_core.sv -----
// Top level of the lane-split 256-bin byte histogram.
//
// Items arrive on req (valid/ready): a count item adds up to four bytes of
// data_bytes, byte k into lane histogram k mod LANES; a read item returns the
// saturated sum over lanes of bin bin_index on rsp; a clear item zeroes all
// bins. Unused command codes are accepted and dropped. Only read items give a
// result, carrying bin_count and bin_echo.
// A two-entry queue separates intake from the histogram sequencer, so req
// keeps taking items while the sequencer works or rsp is stalled, until the
// queue is full.
// Steps in the sequencer: a count item makes ceil(4 / LANES) passes, with one
// read and one write of every lane memory per pass; a read item reads bin
// bin_index of every lane memory, accumulates the lane sum one lane per cycle
// and then moves the sum into the result register; a clear item runs the sweep.
// After reset, and during a clear, a sweep writes zero to one bin of every lane
// memory per cycle through all 256 bins; req.ready is low during the sweep.
// A stalled rsp holds the result in its output register; the sequencer waits
// only when a second result is ready before the first is taken.
module byte_histogram_lanes_core #(
  parameter int LANES      = bhl_pkg::LANES_DEFAULT,
  parameter int COUNT_BITS = bhl_pkg::COUNT_BITS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  bhl_req_if.sink   req,
  bhl_rsp_if.source rsp
);

  logic            q_valid;
  logic            q_ready;
  bhl_pkg::entry_t q_item;
  logic            sweeping;

  bhl_front u_front (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .sweeping (sweeping),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  bhl_back #(
    .LANES      (LANES),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item),
    .sweeping (sweeping),
    .rsp      (rsp)
  );

endmodule

// ----- rtl/bhl_front.sv -----
// Front end: accepts request items, classifies them and queues them for the back end.
module bhl_front (
  input  logic            clk,
  input  logic            rst,
  bhl_req_if.sink         req,
  input  logic            sweeping,
  output logic            q_valid,
  input  logic            q_ready,
  output bhl_pkg::entry_t q_item
);

  localparam int PTR_W = (bhl_pkg::QUEUE_DEPTH > 1) ? $clog2(bhl_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(bhl_pkg::QUEUE_DEPTH + 1);

  bhl_pkg::entry_t entries [bhl_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  bhl_pkg::entry_t entry_in;
  logic            keep;
  logic            accept;
  logic            push;
  logic            pop;

  // Unused commands and count items without bytes are taken and dropped here.
  always_comb begin
    keep                = 1'b0;
    entry_in.op         = bhl_pkg::OP_COUNT;
    entry_in.data_bytes = req.data_bytes;
    entry_in.bin_index  = req.bin_index;
    if (req.byte_count > bhl_pkg::NBYTES_BITS'(bhl_pkg::BYTES_PER_ITEM)) begin
      entry_in.byte_count = bhl_pkg::NBYTES_BITS'(bhl_pkg::BYTES_PER_ITEM);
    end else begin
      entry_in.byte_count = req.byte_count;
    end
    unique case (req.command)
      bhl_pkg::CMD_COUNT: begin
        entry_in.op = bhl_pkg::OP_COUNT;
        keep        = (req.byte_count != '0);
      end
      bhl_pkg::CMD_READ: begin
        entry_in.op = bhl_pkg::OP_READ;
        keep        = 1'b1;
      end
      bhl_pkg::CMD_CLEAR: begin
        entry_in.op = bhl_pkg::OP_CLEAR;
        keep        = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign req.ready = (fill != CNT_W'(bhl_pkg::QUEUE_DEPTH)) && !sweeping;
  assign accept    = req.valid && req.ready;
  assign push      = accept && keep;
  assign q_valid   = (fill != '0);
  assign q_item    = entries[rd_ptr];
  assign pop       = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= entry_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ----- rtl/bhl_back.sv -----
// Back end: lane histogram memories, count/read/clear sequencer and result register.
module bhl_back #(
  parameter int LANES      = bhl_pkg::LANES_DEFAULT,
  parameter int COUNT_BITS = bhl_pkg::COUNT_BITS_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  output logic            q_ready,
  input  bhl_pkg::entry_t q_item,
  output logic            sweeping,
  bhl_rsp_if.source       rsp
);

  localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int PASSES = (bhl_pkg::BYTES_PER_ITEM + LANES - 1) / LANES;
  localparam int PASS_W = (PASSES > 1) ? $clog2(PASSES) : 1;
  localparam int EXT_W  = (COUNT_BITS > bhl_pkg::OUT_BITS) ? COUNT_BITS : bhl_pkg::OUT_BITS;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [6:0] {
    S_INIT    = 7'b0000001,
    S_IDLE    = 7'b0000010,
    S_CNT_RD  = 7'b0000100,
    S_CNT_WR  = 7'b0001000,
    S_SUM_RD  = 7'b0010000,
    S_SUM_ACC = 7'b0100000,
    S_RESULT  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  bhl_pkg::entry_t                cur;
  logic [PASS_W-1:0]              pass;
  logic [LANE_W-1:0]              lane_idx;
  logic [bhl_pkg::BIN_BITS-1:0]   clr_addr;
  logic [COUNT_BITS-1:0]          acc;
  logic [COUNT_BITS:0]            acc_sum;
  logic [EXT_W-1:0]               acc_ext;

  logic                           out_valid;
  logic [bhl_pkg::OUT_BITS-1:0]   out_count;
  logic [bhl_pkg::BIN_BITS-1:0]   out_echo;
  logic                           out_free;

  logic                           lane_en   [LANES];
  logic [bhl_pkg::BIN_BITS-1:0]   lane_bin  [LANES];
  logic                           mem_we    [LANES];
  logic [bhl_pkg::BIN_BITS-1:0]   mem_waddr [LANES];
  logic [COUNT_BITS-1:0]          mem_wdata [LANES];
  logic [bhl_pkg::BIN_BITS-1:0]   mem_raddr [LANES];
  logic [COUNT_BITS-1:0]          rdata     [LANES];

  // Byte position k goes to lane k mod LANES during pass k / LANES.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      lane_en[l]  = 1'b0;
      lane_bin[l] = '0;
      for (int k = 0; k < bhl_pkg::BYTES_PER_ITEM; k++) begin
        if ((k % LANES) == l && (k / LANES) == int'(pass)) begin
          lane_en[l]  = (bhl_pkg::NBYTES_BITS'(k) < cur.byte_count);
          lane_bin[l] = cur.data_bytes[8*k +: 8];
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      mem_raddr[l] = (state == S_CNT_RD) ? lane_bin[l] : cur.bin_index;
      if (state == S_INIT) begin
        mem_we[l]    = 1'b1;
        mem_waddr[l] = clr_addr;
        mem_wdata[l] = '0;
      end else begin
        mem_we[l]    = (state == S_CNT_WR) && lane_en[l];
        mem_waddr[l] = lane_bin[l];
        mem_wdata[l] = (rdata[l] == COUNT_MAX) ? rdata[l] : rdata[l] + 1'b1;
      end
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    logic [COUNT_BITS-1:0] mem [bhl_pkg::BINS];

    always_ff @(posedge clk) begin
      if (mem_we[g]) begin
        mem[mem_waddr[g]] <= mem_wdata[g];
      end
      rdata[g] <= mem[mem_raddr[g]];
    end
  end

  assign acc_sum  = {1'b0, acc} + {1'b0, rdata[lane_idx]};
  assign acc_ext  = EXT_W'(acc);
  assign out_free = !out_valid || rsp.ready;
  assign sweeping = (state == S_INIT);
  assign q_ready  = (state == S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT: begin
        if (clr_addr == bhl_pkg::BIN_BITS'(bhl_pkg::BINS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          unique case (q_item.op)
            bhl_pkg::OP_COUNT: state_next = S_CNT_RD;
            bhl_pkg::OP_READ:  state_next = S_SUM_RD;
            bhl_pkg::OP_CLEAR: state_next = S_INIT;
            default:           state_next = S_IDLE;
          endcase
        end
      end
      S_CNT_RD:  state_next = S_CNT_WR;
      S_CNT_WR: begin
        state_next = (pass == PASS_W'(PASSES - 1)) ? S_IDLE : S_CNT_RD;
      end
      S_SUM_RD:  state_next = S_SUM_ACC;
      S_SUM_ACC: begin
        if (lane_idx == LANE_W'(LANES - 1)) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_INIT) begin
        clr_addr <= clr_addr + 1'b1;
      end else begin
        clr_addr <= '0;
      end
      if (state == S_RESULT && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_valid) begin
      cur <= q_item;
    end
    if (state == S_IDLE) begin
      pass <= '0;
    end else if (state == S_CNT_WR) begin
      pass <= pass + 1'b1;
    end
    if (state == S_SUM_RD) begin
      acc      <= '0;
      lane_idx <= '0;
    end else if (state == S_SUM_ACC) begin
      acc      <= acc_sum[COUNT_BITS] ? COUNT_MAX : acc_sum[COUNT_BITS-1:0];
      lane_idx <= lane_idx + 1'b1;
    end
    if (state == S_RESULT && out_free) begin
      out_count <= (acc_ext > EXT_W'(bhl_pkg::OUT_MAX)) ? bhl_pkg::OUT_MAX
                                                        : acc_ext[bhl_pkg::OUT_BITS-1:0];
      out_echo  <= cur.bin_index;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.bin_count = out_count;
  assign rsp.bin_echo  = out_echo;

endmodule

// ----- bench/bhl_checker.sv -----
// Checker of the byte histogram: models the lane histograms and compares every bin result.
module bhl_checker #(
  parameter int LANES      = bhl_pkg::LANES_DEFAULT,
  parameter int COUNT_BITS = bhl_pkg::COUNT_BITS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  bhl_req_if   req,
  bhl_rsp_if   rsp,
  output int   mismatches,
  output int   outstanding
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [bhl_pkg::OUT_BITS-1:0] bin_count;
    logic [bhl_pkg::BIN_BITS-1:0] bin_echo;
  } bin_answer_t;

  logic [COUNT_BITS-1:0] lane_hist [LANES][bhl_pkg::BINS];
  bin_answer_t           bin_answers_q [$];

  function automatic void wipe_bins();
    for (int l = 0; l < LANES; l++)
      for (int b = 0; b < bhl_pkg::BINS; b++)
        lane_hist[l][b] = '0;
  endfunction

  // The lane sum saturates at the counter maximum first, then at the output width.
  function automatic logic [bhl_pkg::OUT_BITS-1:0] lane_total(
    input logic [bhl_pkg::BIN_BITS-1:0] bin);
    logic [COUNT_BITS-1:0] acc;
    logic [COUNT_BITS-1:0] cnt;
    acc = '0;
    for (int l = 0; l < LANES; l++) begin
      cnt = lane_hist[l][bin];
      if (acc > COUNT_MAX - cnt) acc = COUNT_MAX;
      else acc = acc + cnt;
    end
    if (COUNT_BITS > bhl_pkg::OUT_BITS && acc > COUNT_BITS'(bhl_pkg::OUT_MAX))
      return bhl_pkg::OUT_MAX;
    return bhl_pkg::OUT_BITS'(acc);
  endfunction

  function automatic void tally_bytes(input logic [bhl_pkg::DATA_BITS-1:0]   data,
                                      input logic [bhl_pkg::NBYTES_BITS-1:0] n);
    int                           used;
    int                           lane;
    logic [bhl_pkg::BIN_BITS-1:0] b;
    used = (n > bhl_pkg::BYTES_PER_ITEM) ? bhl_pkg::BYTES_PER_ITEM : int'(n);
    for (int k = 0; k < used; k++) begin
      b    = data[8*k +: 8];
      lane = k % LANES;
      if (lane_hist[lane][b] != COUNT_MAX) lane_hist[lane][b] = lane_hist[lane][b] + 1'b1;
    end
  endfunction

  function automatic void note_failure(input string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("%s", msg);
  endfunction

  always @(posedge clk) begin
    bin_answer_t want;
    if (rst) begin
      wipe_bins();
      bin_answers_q.delete();
      mismatches  = 0;
    end else begin
      // Results are compared before the request of this edge is applied, so a
      // result that arrives alongside a new read is never paired with it.
      if (rsp.valid && rsp.ready) begin
        if (bin_answers_q.size() == 0) begin
          note_failure($sformatf("result with no read waiting: count %0d bin %0d",
                                 rsp.bin_count, rsp.bin_echo));
        end else begin
          want = bin_answers_q.pop_front();
          if (rsp.bin_count !== want.bin_count || rsp.bin_echo !== want.bin_echo)
            note_failure($sformatf({"bin result mismatch: expected count %0d bin %0d,",
                                    " got count %0d bin %0d"},
                                   want.bin_count, want.bin_echo,
                                   rsp.bin_count, rsp.bin_echo));
        end
      end
      if (req.valid && req.ready) begin
        case (bhl_pkg::op_t'(req.command))
          bhl_pkg::OP_COUNT: tally_bytes(req.data_bytes, req.byte_count);
          bhl_pkg::OP_READ: begin
            want.bin_count = lane_total(req.bin_index);
            want.bin_echo  = req.bin_index;
            bin_answers_q.insert(bin_answers_q.size(), want);
          end
          bhl_pkg::OP_CLEAR: wipe_bins();
          default: ;
        endcase
      end
    end
    outstanding = bin_answers_q.size();
  end

endmodule

// ----- bench/tb.sv -----
// Testbench top of the byte histogram: drives items, throttles results and reports the verdict.
module tb;

  localparam logic [bhl_pkg::CMD_BITS-1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS  = 700;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 300;
  localparam int IDLE_PERCENT  = 34;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   mismatches;
  int   outstanding;
  bit   tx_calm;
  bit   rx_calm;
  int   hold_req;

  bhl_req_if req_ch ();
  bhl_rsp_if rsp_ch ();

  byte_histogram_lanes_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  bhl_checker #(
    .LANES      (bhl_pkg::LANES_DEFAULT),
    .COUNT_BITS (bhl_pkg::COUNT_BITS_DEFAULT)
  ) hist_check (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #8_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Result side: random back-pressure, a long hold-off on request, calm windows.
  initial begin : rsp_sink
    int hold_left;
    int hold_seen;
    hold_left    = 0;
    hold_seen    = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= rx_calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic offer_item(input logic [bhl_pkg::CMD_BITS-1:0]    cmd,
                            input logic [bhl_pkg::DATA_BITS-1:0]   data,
                            input logic [bhl_pkg::NBYTES_BITS-1:0] n,
                            input logic [bhl_pkg::BIN_BITS-1:0]    bin);
    if (!tx_calm) begin
      while ($urandom_range(0, 99) < IDLE_PERCENT) begin
        req_ch.valid <= 1'b0;
        @(negedge clk);
      end
    end
    req_ch.valid      <= 1'b1;
    req_ch.command    <= cmd;
    req_ch.data_bytes <= data;
    req_ch.byte_count <= n;
    req_ch.bin_index  <= bin;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Half of the bytes come from a few hot values so that bins build up counts.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 11))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h41;
      3:       return 8'h80;
      4:       return 8'h7F;
      5:       return 8'h01;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [bhl_pkg::NBYTES_BITS-1:0] pick_count();
    if ($urandom_range(0, 9) < 6) return bhl_pkg::NBYTES_BITS'(bhl_pkg::BYTES_PER_ITEM);
    return bhl_pkg::NBYTES_BITS'($urandom_range(0, 7));
  endfunction

  function automatic logic [bhl_pkg::NBYTES_BITS-1:0] any_count();
    return bhl_pkg::NBYTES_BITS'($urandom);
  endfunction

  function automatic logic [bhl_pkg::BIN_BITS-1:0] any_bin();
    return bhl_pkg::BIN_BITS'($urandom);
  endfunction

  function automatic logic [bhl_pkg::DATA_BITS-1:0] pick_word();
    return {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
  endfunction

  initial begin : stimulus
    int done;
    int r;
    req_ch.valid      = 1'b0;
    req_ch.command    = bhl_pkg::CMD_COUNT;
    req_ch.data_bytes = '0;
    req_ch.byte_count = '0;
    req_ch.bin_index  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: empty bins, lane edges, byte counts beyond four, clear.
    offer_item(bhl_pkg::CMD_READ,  $urandom,     any_count(), 8'h00);
    offer_item(bhl_pkg::CMD_READ,  $urandom,     any_count(), 8'hFF);
    offer_item(bhl_pkg::CMD_COUNT, 32'hFFFFFFFF, 3'd4,        any_bin());
    offer_item(bhl_pkg::CMD_COUNT, 32'h00000000, 3'd4,        any_bin());
    offer_item(bhl_pkg::CMD_COUNT, 32'h41414141, 3'd0,        any_bin());
    offer_item(bhl_pkg::CMD_COUNT, 32'h41424344, 3'd1,        any_bin());
    offer_item(bhl_pkg::CMD_COUNT, 32'h41424344, 3'd2,        any_bin());
    offer_item(bhl_pkg::CMD_COUNT, 32'h41424344, 3'd3,        any_bin());
    offer_item(bhl_pkg::CMD_COUNT, 32'h41424344, 3'd5,        any_bin());
    offer_item(bhl_pkg::CMD_COUNT, 32'h41414141, 3'd7,        any_bin());
    offer_item(CMD_UNUSED,         32'hFFFFFFFF, 3'd7,        8'hFF);
    offer_item(bhl_pkg::CMD_READ,  $urandom,     any_count(), 8'hFF);
    offer_item(bhl_pkg::CMD_READ,  $urandom,     any_count(), 8'h00);
    offer_item(bhl_pkg::CMD_READ,  $urandom,     any_count(), 8'h41);
    offer_item(bhl_pkg::CMD_READ,  $urandom,     any_count(), 8'h42);
    offer_item(bhl_pkg::CMD_READ,  $urandom,     any_count(), 8'h43);
    offer_item(bhl_pkg::CMD_READ,  $urandom,     any_count(), 8'h44);
    offer_item(bhl_pkg::CMD_CLEAR, $urandom,     any_count(), any_bin());
    offer_item(bhl_pkg::CMD_READ,  $urandom,     any_count(), 8'h41);
    offer_item(bhl_pkg::CMD_READ,  $urandom,     any_count(), 8'hFF);
    offer_item(bhl_pkg::CMD_COUNT, 32'h80017FFE, 3'd6,        any_bin());
    offer_item(bhl_pkg::CMD_READ,  $urandom,     any_count(), 8'h80);
    offer_item(bhl_pkg::CMD_READ,  $urandom,     any_count(), 8'hFE);

    done = 0;
    while (done < RANDOM_ITEMS) begin
      if (done == 200) begin
        // Results are held off while reads keep coming, so the block backs up.
        hold_req++;
        tx_calm = 1'b1;
        repeat (12) offer_item(bhl_pkg::CMD_READ, $urandom, any_count(), pick_byte());
        tx_calm = 1'b0;
        done += 12;
      end
      if (done == 400) begin
        while (outstanding != 0) @(negedge clk);
      end
      if (done == 450) begin
        tx_calm = 1'b1;
        rx_calm = 1'b1;
      end
      if (done == 560) begin
        tx_calm = 1'b0;
        rx_calm = 1'b0;
      end
      r = $urandom_range(0, 99);
      if (r < 58) begin
        offer_item(bhl_pkg::CMD_COUNT,
                   ($urandom_range(0, 3) == 0) ? $urandom : pick_word(),
                   pick_count(), any_bin());
        done++;
      end else if (r < 92) begin
        offer_item(bhl_pkg::CMD_READ, $urandom, any_count(), pick_byte());
        done++;
      end else if (r < 95) begin
        offer_item(bhl_pkg::CMD_CLEAR, $urandom, any_count(), any_bin());
        done++;
      end else begin
        offer_item(CMD_UNUSED, $urandom, any_count(), any_bin());
      end
    end

    req_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
